### sv/pgalloc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the page allocator
package pgalloc_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W      = 64;
    localparam int DELTA_W     = 17;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 16;
    localparam int ACTION_W    = 2;
    localparam int CFG_IDX_W   = 2;

    // Parameter defaults (PAGE_BYTES must be a power of two)
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int COUNT_BITS_DEF = 16;

    // Register reset values
    localparam logic [ADDR_W-1:0] BASE_RST = 64'h0000_0000_8000_0000;
    localparam logic [ADDR_W-1:0] TOP_RST  = 64'h0000_0000_8800_0000;
    localparam logic [ADDR_W-1:0] KEND_RST = 64'h0000_0000_8000_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEND = 2'd2;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FREED   = 3'd1,
        ST_HELD    = 3'd2,
        ST_OOM     = 3'd3,
        ST_BADADDR = 3'd4,
        ST_UNDER   = 3'd5,
        ST_OVER    = 3'd6,
        ST_FULL    = 3'd7
    } t_status;

    // Request class decided by the front end
    typedef enum logic [2:0] {
        K_NOP    = 3'd0,
        K_ALLOC  = 3'd1,
        K_FREE   = 3'd2,
        K_UPDATE = 3'd3,
        K_BAD    = 3'd4
    } t_kind;

    localparam int KIND_W = $bits(t_kind);

endpackage

### sv/pgalloc_queue.sv
`timescale 1ns / 1ps
// Two-entry FIFO between the front end and the back end
module pgalloc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_data [2];
    logic         r_rd_ptr;
    logic         r_wr_ptr;
    logic [1:0]   r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_data[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_data[r_wr_ptr] <= i_data;
    end

endmodule

### sv/pgalloc_front.sv
`timescale 1ns / 1ps
// Front end: holds the region registers, checks addresses and classifies items
module pgalloc_front #(
    parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pgalloc_pkg::PAGE_BYTES_DEF,
    parameter int ENT_W      = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pgalloc_pkg::ADDR_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic [pgalloc_pkg::ACTION_W-1:0]   i_action,
    input  logic [pgalloc_pkg::ADDR_W-1:0]     i_addr,
    input  logic signed [pgalloc_pkg::DELTA_W-1:0] i_delta,
    input  logic                               i_q_full,
    input  logic                               i_clearing,
    output logic                               o_in_stall,
    output logic                               o_push,
    output logic [ENT_W-1:0]                   o_entry,
    output logic [pgalloc_pkg::ADDR_W-1:0]     o_base
);
    import pgalloc_pkg::*;

    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int HI_SHIFT   = PAGE_SHIFT + IDX_W;

    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_top;
    logic [ADDR_W-1:0] r_kend;

    logic [ADDR_W-1:0] off;
    logic [IDX_W-1:0]  idx;
    logic              in_region;
    logic              above_kernel;
    t_kind             kind;

    // Region registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RST;
            r_top  <= TOP_RST;
            r_kend <= KEND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE: r_base <= i_cfg_data;
                CFG_TOP:  r_top  <= i_cfg_data;
                CFG_KEND: r_kend <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign o_base = r_base;

    // Page index and range checks shared by free and update
    assign off          = i_addr - r_base;
    assign idx          = off[PAGE_SHIFT +: IDX_W];
    assign above_kernel = (i_addr >= r_kend);
    assign in_region    = (i_addr[PAGE_SHIFT-1:0] == '0)
                       && (i_addr >= r_base) && (i_addr < r_top)
                       && ((off >> HI_SHIFT) == '0)
                       && ({1'b0, idx} < (IDX_W+1)'(NUM_PAGES));

    // Classify the item
    always_comb begin
        case (i_action)
            ACT_ALLOC:  kind = K_ALLOC;
            ACT_FREE:   kind = (in_region && above_kernel) ? K_FREE : K_BAD;
            ACT_UPDATE: kind = in_region ? K_UPDATE : K_BAD;
            default:    kind = K_NOP;
        endcase
    end

    // Handshake into the queue; nothing enters during the count clearing pass
    assign o_in_stall = i_q_full | i_clearing;
    assign o_push     = i_in_valid & ~o_in_stall;
    assign o_entry    = {kind, idx, i_delta};

endmodule

### sv/pgalloc_back.sv
`timescale 1ns / 1ps
// Back end: count and free stack memories, read-modify-write sequencer, result register
module pgalloc_back #(
    parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pgalloc_pkg::PAGE_BYTES_DEF,
    parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF,
    parameter int ENT_W      = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [ENT_W-1:0]                     i_q_data,
    input  logic [pgalloc_pkg::ADDR_W-1:0]       i_base,
    input  logic                                 i_out_stall,
    output logic                                 o_q_pop,
    output logic                                 o_clearing,
    output logic                                 o_out_valid,
    output logic [pgalloc_pkg::STATUS_W-1:0]     o_status,
    output logic [pgalloc_pkg::ADDR_W-1:0]       o_page_addr,
    output logic [pgalloc_pkg::COUNT_OUT_W-1:0]  o_count
);
    import pgalloc_pkg::*;

    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int TOP_W      = $clog2(NUM_PAGES + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int SUM_W      = ((COUNT_BITS > DELTA_W) ? COUNT_BITS : DELTA_W) + 2;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // Low output bits of a count
    function automatic logic [COUNT_OUT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[COUNT_OUT_W-1:0];
    endfunction

    logic [COUNT_BITS-1:0] mem_cnt [NUM_PAGES];
    logic [IDX_W-1:0]      mem_stk [NUM_PAGES];

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_clr_idx;
    logic [TOP_W-1:0]      r_top, n_top;
    t_kind                 r_kind;
    logic [IDX_W-1:0]      r_idx;
    logic [DELTA_W-1:0]    r_delta;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [IDX_W-1:0]      r_stk_rd;
    logic                  r_out_valid;
    t_status               r_status, n_status;
    logic [ADDR_W-1:0]     r_page, n_page;
    logic [COUNT_OUT_W-1:0] r_count, n_count;

    t_kind                 q_kind;
    logic [IDX_W-1:0]      q_idx;
    logic [DELTA_W-1:0]    q_delta;
    logic [TOP_W-1:0]      top_dec;
    logic [IDX_W-1:0]      stk_raddr;
    logic                  fire;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [SUM_W-1:0]      sum;
    logic                  sum_under;
    logic                  sum_over;

    logic                  x_cnt_we;
    logic [IDX_W-1:0]      x_cnt_waddr;
    logic [COUNT_BITS-1:0] x_cnt_wdata;
    logic                  x_stk_we;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  stk_we;

    // Queue entry fields
    assign q_kind  = t_kind'(i_q_data[ENT_W-1 -: KIND_W]);
    assign q_idx   = i_q_data[DELTA_W +: IDX_W];
    assign q_delta = i_q_data[DELTA_W-1:0];

    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign fire       = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign top_dec   = r_top - TOP_W'(1);
    assign stk_raddr = top_dec[IDX_W-1:0];

    // Count arithmetic on the value read from memory
    assign cnt_dec   = r_cnt_rd - COUNT_BITS'(1);
    assign sum       = {{(SUM_W-COUNT_BITS){1'b0}}, r_cnt_rd}
                     + {{(SUM_W-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
    assign sum_under = sum[SUM_W-1];
    assign sum_over  = !sum_under && (sum[SUM_W-1:COUNT_BITS] != '0);

    // Result and memory updates for the item in execution
    always_comb begin
        n_status    = ST_OK;
        n_page      = '0;
        n_count     = '0;
        n_top       = r_top;
        x_cnt_we    = 1'b0;
        x_cnt_waddr = r_idx;
        x_cnt_wdata = '0;
        x_stk_we    = 1'b0;
        case (r_kind)
            K_ALLOC: begin
                if (r_top == '0) begin
                    n_status = ST_OOM;
                end else begin
                    n_top       = top_dec;
                    x_cnt_we    = 1'b1;
                    x_cnt_waddr = r_stk_rd;
                    x_cnt_wdata = COUNT_BITS'(1);
                    n_page      = i_base + (ADDR_W'(r_stk_rd) << PAGE_SHIFT);
                    n_count     = COUNT_OUT_W'(1);
                end
            end
            K_FREE: begin
                if (r_cnt_rd == '0) begin
                    n_status = ST_UNDER;
                end else if (cnt_dec != '0) begin
                    n_status    = ST_HELD;
                    x_cnt_we    = 1'b1;
                    x_cnt_wdata = cnt_dec;
                    n_count     = cnt_out(cnt_dec);
                end else if (r_top == TOP_W'(NUM_PAGES)) begin
                    n_status = ST_FULL;
                    n_count  = cnt_out(r_cnt_rd);
                end else begin
                    // last reference dropped: page goes back on the stack
                    n_status = ST_FREED;
                    x_cnt_we = 1'b1;
                    x_stk_we = 1'b1;
                    n_top    = r_top + TOP_W'(1);
                end
            end
            K_UPDATE: begin
                if (sum_under) begin
                    n_status = ST_UNDER;
                    n_count  = cnt_out(r_cnt_rd);
                end else if (sum_over) begin
                    n_status = ST_OVER;
                    n_count  = cnt_out(r_cnt_rd);
                end else begin
                    x_cnt_we    = 1'b1;
                    x_cnt_wdata = sum[COUNT_BITS-1:0];
                    n_count     = cnt_out(sum[COUNT_BITS-1:0]);
                end
            end
            K_BAD:   n_status = ST_BADADDR;
            default: n_status = ST_OK;
        endcase
    end

    // Count memory write port: clearing pass or executed item
    assign cnt_we    = o_clearing | (fire & x_cnt_we);
    assign cnt_waddr = o_clearing ? r_clr_idx : x_cnt_waddr;
    assign cnt_wdata = o_clearing ? COUNT_BITS'(1) : x_cnt_wdata;
    assign stk_we    = fire & x_stk_we;

    // Reference count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) mem_cnt[cnt_waddr] <= cnt_wdata;
        if (o_q_pop) r_cnt_rd <= mem_cnt[q_idx];
    end

    // Free page stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) mem_stk[r_top[IDX_W-1:0]] <= r_idx;
        if (o_q_pop) r_stk_rd <= mem_stk[stk_raddr];
    end

    // Sequencer next state
    always_comb begin
        case (r_state)
            S_CLEAR: n_state = (r_clr_idx == IDX_W'(NUM_PAGES - 1)) ? S_IDLE : S_CLEAR;
            S_IDLE:  n_state = i_q_valid ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = fire ? S_IDLE : S_EXEC;
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_clearing) r_clr_idx <= r_clr_idx + IDX_W'(1);
            if (fire) r_top <= n_top;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind  <= q_kind;
            r_idx   <= q_idx;
            r_delta <= q_delta;
        end
        if (fire) begin
            r_status <= n_status;
            r_page   <= n_page;
            r_count  <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_page_addr = r_page;
    assign o_count     = r_count;

endmodule

### sv/page_allocator_with_refcount_core.sv
`timescale 1ns / 1ps
// Path: queue entry, memory read and item registers, then the result register.
// The back end takes no new item until the last one has executed; it reads the
// count and free stack memories, then writes them; an unaccepted result stalls it.
// Reset: synchronous, active low; afterwards a clearing pass sets every page count
// to one with the input stalled. The free stack starts empty.
module page_allocator_with_refcount_core #(
    parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pgalloc_pkg::PAGE_BYTES_DEF,
    parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pgalloc_pkg::ADDR_W-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [pgalloc_pkg::ACTION_W-1:0]       i_action,
    input  logic [pgalloc_pkg::ADDR_W-1:0]         i_addr,
    input  logic signed [pgalloc_pkg::DELTA_W-1:0] i_delta,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [pgalloc_pkg::STATUS_W-1:0]       o_status,
    output logic [pgalloc_pkg::ADDR_W-1:0]         o_page_addr,
    output logic [pgalloc_pkg::COUNT_OUT_W-1:0]    o_count
);
    import pgalloc_pkg::*;

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int ENT_W = KIND_W + IDX_W + DELTA_W;
    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

    logic              w_push;
    logic [ENT_W-1:0]  w_entry;
    logic              w_q_valid;
    logic              w_q_full;
    logic [ENT_W-1:0]  w_q_data;
    logic              w_q_pop;
    logic              w_clearing;
    logic [ADDR_W-1:0] w_base;

    pgalloc_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .ENT_W      (ENT_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_addr     (i_addr),
        .i_delta    (i_delta),
        .i_q_full   (w_q_full),
        .i_clearing (w_clearing),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_entry    (w_entry),
        .o_base     (w_base)
    );

    pgalloc_queue #(
        .W (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_q_data)
    );

    pgalloc_back #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES),
        .COUNT_BITS (COUNT_BITS),
        .ENT_W      (ENT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .i_base      (w_base),
        .i_out_stall (i_out_stall),
        .o_q_pop     (w_q_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_page_addr (o_page_addr),
        .o_count     (o_count)
    );

`ifndef SYNTHESIS
    // No result appears while counts are still being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !w_clearing)
        else $error("result raised during count clearing");

    // An allocated page lies on a page boundary of the region
    a_alloc_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK && o_page_addr != '0)
        |-> (((o_page_addr - w_base) & PAGE_MASK) == '0))
        else $error("allocated page not aligned to the region");

    // A freed page reports neither an address nor a count
    a_freed_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FREED) |-> (o_count == '0 && o_page_addr == '0))
        else $error("freed result carries a count or address");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
    import pgalloc_pkg::*;

    localparam int NPG          = NUM_PAGES_DEF;
    localparam int PGB          = PAGE_BYTES_DEF;
    localparam int CNT_W        = COUNT_BITS_DEF;
    localparam int IDX_BITS     = $clog2(NPG);
    localparam int CLK_PERIOD   = 8;
    localparam int PHASE_ITEMS  = 195;
    // pages pushed onto the stack before the random traffic
    localparam int POP_PAGES    = 200;
    // the limit lies above the clearing pass after reset, the longest legal silence
    localparam int STALL_LIMIT  = 150000;

    localparam logic [ADDR_W-1:0]   PAGE_SZ  = ADDR_W'(PGB);
    localparam longint              CNT_MAX  = (longint'(1) << CNT_W) - 1;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // handy addresses and deltas for the directed rows (reset window)
    localparam logic [ADDR_W-1:0]  LO_PG = BASE_RST;
    localparam logic [ADDR_W-1:0]  HI_PG = TOP_RST - PAGE_SZ;
    localparam logic [DELTA_W-1:0] D_MAX = 17'h0FFFF;
    localparam logic [DELTA_W-1:0] D_MIN = 17'h10000;
    localparam logic [DELTA_W-1:0] D_M1  = 17'h1FFFF;

    typedef struct packed {
        t_status                 status;
        logic [ADDR_W-1:0]       page;
        logic [COUNT_OUT_W-1:0]  count;
    } t_page_result;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [ADDR_W-1:0]   addr;
        logic [DELTA_W-1:0]  delta;
        bit                  typed;
        t_page_result        want;
    } t_stim_row;

    localparam t_page_result NO_RES = '0;
    localparam int DIR_N = 24;

    // Directed rows: typed expectations where they are obvious, else predicted
    t_stim_row dir_rows [DIR_N] = '{
        '{ACT_ALLOC,  64'd0,                 17'd0,  1'b1, '{ST_OOM,     64'd0, 16'd0}},
        '{ACT_FREE,   LO_PG + 64'd1,         17'd0,  1'b1, '{ST_BADADDR, 64'd0, 16'd0}},
        '{ACT_FREE,   64'd0,                 17'd0,  1'b1, '{ST_BADADDR, 64'd0, 16'd0}},
        '{ACT_FREE,   TOP_RST,               17'd0,  1'b1, '{ST_BADADDR, 64'd0, 16'd0}},
        '{ACT_FREE,   '1,                    D_M1,   1'b1, '{ST_BADADDR, 64'd0, 16'd0}},
        '{ACT_UPDATE, LO_PG - PAGE_SZ,       17'd1,  1'b1, '{ST_BADADDR, 64'd0, 16'd0}},
        '{ACT_UPDATE, LO_PG,                 D_MAX,  1'b1, '{ST_OVER,    64'd0, 16'd1}},
        '{ACT_UPDATE, LO_PG,                 D_MIN,  1'b1, '{ST_UNDER,   64'd0, 16'd1}},
        '{ACT_UPDATE, LO_PG,                 D_M1,   1'b1, '{ST_OK,      64'd0, 16'd0}},
        '{ACT_FREE,   LO_PG,                 17'd0,  1'b1, '{ST_UNDER,   64'd0, 16'd0}},
        '{ACT_UPDATE, LO_PG,                 D_MAX,  1'b1, '{ST_OK,      64'd0, 16'hFFFF}},
        '{ACT_UPDATE, LO_PG,                 17'd1,  1'b1, '{ST_OVER,    64'd0, 16'hFFFF}},
        '{ACT_FREE,   LO_PG,                 17'd0,  1'b1, '{ST_HELD,    64'd0, 16'hFFFE}},
        '{ACT_UPDATE, LO_PG,                 17'h10003, 1'b1, '{ST_OK,   64'd0, 16'd1}},
        '{ACT_FREE,   LO_PG,                 17'd0,  1'b1, '{ST_FREED,   64'd0, 16'd0}},
        '{ACT_ALLOC,  64'd0,                 17'd0,  1'b1, '{ST_OK,      LO_PG, 16'd1}},
        '{ACT_FREE,   HI_PG,                 17'd0,  1'b1, '{ST_FREED,   64'd0, 16'd0}},
        '{ACT_FREE,   HI_PG,                 17'd0,  1'b1, '{ST_UNDER,   64'd0, 16'd0}},
        '{ACT_FREE,   LO_PG + PAGE_SZ,       17'd0,  1'b0, NO_RES},
        '{ACT_ALLOC,  64'd0,                 17'd0,  1'b0, NO_RES},
        '{ACT_ALLOC,  64'd0,                 17'd0,  1'b0, NO_RES},
        '{ACT_NONE,   '1,                    D_M1,   1'b1, '{ST_OK,      64'd0, 16'd0}},
        '{ACT_UPDATE, HI_PG + 64'h800,       17'd1,  1'b1, '{ST_BADADDR, 64'd0, 16'd0}},
        '{ACT_UPDATE, LO_PG + 2 * PAGE_SZ,   17'd0,  1'b0, NO_RES}
    };

    // DUT ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [ADDR_W-1:0]         i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [ACTION_W-1:0]       i_action;
    logic [ADDR_W-1:0]         i_addr;
    logic signed [DELTA_W-1:0] i_delta;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [STATUS_W-1:0]       o_status;
    logic [ADDR_W-1:0]         o_page_addr;
    logic [COUNT_OUT_W-1:0]    o_count;

    page_allocator_with_refcount_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_addr      (i_addr),
        .i_delta     (i_delta),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_page_addr (o_page_addr),
        .o_count     (o_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Allocator image kept by the testbench
    logic [IDX_BITS-1:0]    frame_stack [NPG];
    int unsigned            frame_depth;
    logic [CNT_W-1:0]       frame_refs [NPG+1];
    logic [ADDR_W-1:0]      win_base, win_top, win_kend;

    // pages not on the free stack, with swap-remove positions (-1 when stacked)
    int unsigned held_q [$];
    int          held_pos [NPG];

    t_page_result pending_results [$];
    int           err_count = 0;
    bit           quiet = 1'b0;
    int unsigned  idle_cycles = 0;

    // Page index of an address, or 0 when the address names no managed page
    function automatic bit page_of(input logic [ADDR_W-1:0] addr, input bit above_kernel,
                                   output int unsigned idx);
        logic [ADDR_W-1:0] pg;
        idx = 0;
        if ((addr % PAGE_SZ) != 0) return 1'b0;
        if (above_kernel && addr < win_kend) return 1'b0;
        if (addr < win_base || addr >= win_top) return 1'b0;
        pg = (addr - win_base) / PAGE_SZ;
        if (pg >= ADDR_W'(NPG)) return 1'b0;
        idx = pg[31:0];
        return 1'b1;
    endfunction

    // Applies one request to the image; touched is the page it acted on, or -1
    function automatic t_page_result predict_page_op(input logic [ACTION_W-1:0] act,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic signed [DELTA_W-1:0] delta,
                                                     output int touched);
        t_page_result     res;
        int unsigned      idx;
        logic [CNT_W-1:0] cnt;
        longint           sum;
        res = NO_RES;
        touched = -1;
        case (act)
            ACT_ALLOC: begin
                if (frame_depth == 0) begin
                    res.status = ST_OOM;
                end else begin
                    frame_depth--;
                    idx = 32'(frame_stack[frame_depth]);
                    frame_refs[idx] = CNT_W'(1);
                    res.page  = win_base + ADDR_W'(idx) * PAGE_SZ;
                    res.count = COUNT_OUT_W'(1);
                    touched = idx;
                end
            end
            ACT_FREE: begin
                if (!page_of(addr, 1'b1, idx)) begin
                    res.status = ST_BADADDR;
                end else begin
                    cnt = frame_refs[idx];
                    touched = idx;
                    if (cnt == 0) begin
                        res.status = ST_UNDER;
                    end else if (cnt != 1) begin
                        frame_refs[idx] = CNT_W'(cnt - 1);
                        res.status = ST_HELD;
                        res.count  = COUNT_OUT_W'(cnt - 1);
                    end else if (frame_depth >= NPG) begin
                        res.status = ST_FULL;
                        res.count  = COUNT_OUT_W'(cnt);
                    end else begin
                        frame_refs[idx] = '0;
                        frame_stack[frame_depth] = IDX_BITS'(idx);
                        frame_depth++;
                        res.status = ST_FREED;
                    end
                end
            end
            ACT_UPDATE: begin
                if (!page_of(addr, 1'b0, idx)) begin
                    res.status = ST_BADADDR;
                end else begin
                    cnt = frame_refs[idx];
                    touched = idx;
                    sum = longint'(cnt) + longint'(delta);
                    if (sum < 0) begin
                        res.status = ST_UNDER;
                        res.count  = COUNT_OUT_W'(cnt);
                    end else if (sum > CNT_MAX) begin
                        res.status = ST_OVER;
                        res.count  = COUNT_OUT_W'(cnt);
                    end else begin
                        frame_refs[idx] = CNT_W'(sum);
                        res.count = COUNT_OUT_W'(sum);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Address of a page the sequence currently owns, else of any page
    function automatic logic [ADDR_W-1:0] held_addr();
        int unsigned idx;
        if (held_q.size() != 0) idx = held_q[$urandom_range(0, held_q.size() - 1)];
        else idx = $urandom_range(0, NPG - 1);
        return win_base + ADDR_W'(idx) * PAGE_SZ;
    endfunction

    // Noise addresses: owned and window pages, window edges, misaligned and random values
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 9))
            0, 1, 2: a = held_addr();
            3: a = win_base + ADDR_W'($urandom_range(0, NPG - 1)) * PAGE_SZ;
            4: begin
                case ($urandom_range(0, 6))
                    0: a = win_base;
                    1: a = win_top;
                    2: a = win_top - PAGE_SZ;
                    3: a = win_kend;
                    4: a = win_kend - PAGE_SZ;
                    5: a = win_base + ADDR_W'(NPG) * PAGE_SZ;
                    default: a = win_base - PAGE_SZ;
                endcase
            end
            5, 6: a = {$urandom, $urandom};
            7: a = win_base + ADDR_W'($urandom_range(0, NPG - 1)) * PAGE_SZ
                   + ADDR_W'($urandom_range(1, PGB - 1));
            default: a = {$urandom, $urandom} & ~(PAGE_SZ - 1);
        endcase
        return a;
    endfunction

    // Mostly small steps, sometimes the extremes or any value
    function automatic logic signed [DELTA_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            6: return DELTA_W'($urandom);
            7: return D_MAX;
            8: return D_MIN;
            default: return DELTA_W'(int'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    // Sends one item, then records its expected result and page ownership
    task automatic issue_request(input logic [ACTION_W-1:0] act,
                                 input logic [ADDR_W-1:0] addr,
                                 input logic signed [DELTA_W-1:0] delta,
                                 input bit typed, input t_page_result typed_res);
        int unsigned  gap;
        int           touched;
        int unsigned  last;
        t_page_result res;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_addr     <= addr;
        i_delta    <= delta;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        res = predict_page_op(act, addr, delta, touched);
        pending_results.push_back(typed ? typed_res : res);
        // a page can sit on the stack twice; track each page once
        if (act == ACT_ALLOC && res.status == ST_OK) begin
            if (held_pos[touched] < 0) begin
                held_pos[touched] = held_q.size();
                held_q.push_back(touched);
            end
        end else if (res.status == ST_FREED && held_pos[touched] >= 0) begin
            last = held_q[held_q.size() - 1];
            held_q[held_pos[touched]] = last;
            held_pos[last] = held_pos[touched];
            void'(held_q.pop_back());
            held_pos[touched] = -1;
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Program the managed window (block idle)
    task automatic load_window(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] t,
                               input logic [ADDR_W-1:0] k);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE;
        i_cfg_data <= b;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOP;
        i_cfg_data <= t;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEND;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        win_base = b;
        win_top  = t;
        win_kend = k;
    endtask

    // Stimulus
    initial begin : stimulus
        int                i, ph, n, r;
        logic [ADDR_W-1:0] b, t, k, pg;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BASE;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_ALLOC;
        i_addr     <= '0;
        i_delta    <= '0;

        // image after reset: every page counted once, stack empty
        win_base = BASE_RST;
        win_top  = TOP_RST;
        win_kend = KEND_RST;
        frame_depth = 0;
        for (i = 0; i < NPG; i++) begin
            frame_stack[i] = '0;
            frame_refs[i]  = CNT_W'(1);
            held_pos[i]    = i;
            held_q.push_back(i);
        end
        frame_refs[NPG] = CNT_W'(1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++)
            issue_request(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].delta,
                          dir_rows[i].typed, dir_rows[i].want);

        // Populate the stack by freeing the low pages once (bring each count to one first)
        for (i = 0; i < POP_PAGES; i++) begin
            if (held_pos[i] >= 0) begin
                pg = win_base + ADDR_W'(i) * PAGE_SZ;
                if (frame_refs[i] != 1)
                    issue_request(ACT_UPDATE, pg, DELTA_W'(1 - int'(frame_refs[i])),
                                  1'b0, NO_RES);
                issue_request(ACT_FREE, pg, DELTA_W'($urandom), 1'b0, NO_RES);
            end
        end

        // Revive a stacked page and free it again
        pg = win_base + ADDR_W'($urandom_range(0, POP_PAGES - 1)) * PAGE_SZ;
        issue_request(ACT_UPDATE, pg, 17'd1, 1'b0, NO_RES);
        issue_request(ACT_FREE,   pg, 17'd0, 1'b0, NO_RES);
        issue_request(ACT_UPDATE, pg, 17'd1, 1'b0, NO_RES);
        issue_request(ACT_FREE,   pg, 17'd0, 1'b0, NO_RES);
        issue_request(ACT_FREE,   pg, 17'd0, 1'b0, NO_RES);
        issue_request(ACT_UPDATE, pg, D_M1,  1'b0, NO_RES);

        // Random traffic over several windows
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin b = BASE_RST; t = TOP_RST; k = KEND_RST; end
                1: begin b = BASE_RST; t = 64'h0000_0000_9000_0000; k = BASE_RST + 64'h40_0000; end
                2: begin b = '0; t = '1; k = '0; end
                3: begin b = 64'hFFFF_FFFF_FFFF_F000; t = '1; k = '0; end
                4: begin b = 64'hFFFF_FFFF_F800_0000; t = '1; k = '1; end
                5: begin
                    b = {$urandom, $urandom} & ~(PAGE_SZ - 1);
                    t = b + ADDR_W'($urandom_range(1, 2 * NPG)) * PAGE_SZ;
                    k = b + ADDR_W'($urandom_range(0, NPG)) * PAGE_SZ;
                end
                default: begin b = '1; t = '0; k = '1; end
            endcase
            drain_results();
            load_window(b, t, k);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 63) == 0) quiet = !quiet;
                r = $urandom_range(0, 99);
                if (r < 35)
                    issue_request(ACT_ALLOC, {$urandom, $urandom}, DELTA_W'($urandom),
                                  1'b0, NO_RES);
                else if (r < 65)
                    issue_request(ACT_FREE, held_addr(), pick_delta(), 1'b0, NO_RES);
                else if (r < 85)
                    issue_request(ACT_UPDATE, held_addr(), pick_delta(), 1'b0, NO_RES);
                else
                    issue_request(ACTION_W'($urandom_range(0, 3)), pick_addr(),
                                  DELTA_W'($urandom), 1'b0, NO_RES);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("page_allocator_with_refcount_core test passed");
        end else begin
            $display("page_allocator_with_refcount_core test failed");
        end
        $finish;
    end

    // Result side: random stall per item, compare against the oldest expectation
    initial begin : result_sink
        int unsigned  hold;
        t_page_result want;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 7);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d page %h count %0d",
                         $time, o_status, o_page_addr, o_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                    err_count++;
                end
                if (o_page_addr !== want.page) begin
                    $display("%0t: page_addr mismatch: expected %h, actual %h",
                             $time, want.page, o_page_addr);
                    err_count++;
                end
                if (o_count !== want.count) begin
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, want.count, o_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("page_allocator_with_refcount_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
